// File: rtl/core/keypad_code_lock_assert.svh
// Assertion helpers for the keypad code lock.
// Both expect signals named clock and reset in the module that uses them.
`ifndef KEYPAD_CODE_LOCK_ASSERT_SVH
`define KEYPAD_CODE_LOCK_ASSERT_SVH

// Same-cycle implication.
`define KCL_CHECK_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define KCL_CHECK_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/core/kcl_pkg.sv
package kcl_pkg;

   typedef enum logic [1:0] {
      MODE_LOCKED   = 2'd0,
      MODE_UNLOCKED = 2'd1,
      MODE_CHANGE   = 2'd2,
      MODE_ALARM    = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      ST_OK      = 3'd0,
      ST_MAX     = 3'd1,
      ST_GRANTED = 3'd2,
      ST_WRONG   = 3'd3,
      ST_SHORT   = 3'd4,
      ST_CHANGED = 3'd5,
      ST_IGNORED = 3'd6
   } status_type;

   typedef enum logic [2:0] {
      KEY_DIGIT  = 3'd0,
      KEY_DELETE = 3'd1,
      KEY_CLEAR  = 3'd2,
      KEY_SUBMIT = 3'd3,
      KEY_CHANGE = 3'd4,
      KEY_DOOR   = 3'd5,
      KEY_LIGHT  = 3'd6
   } kind_type;

   // one key event
   typedef struct packed {
      logic [2:0] kind;
      logic [3:0] digit;
   } item_type;

   // one result word
   typedef struct packed {
      mode_type   mode;
      status_type status;
      logic [2:0] digits_entered;
      logic [2:0] wrong_attempts;
      logic       door_open;
      logic       light_on;
   } result_type;

   localparam int          INIT_W     = 17;
   localparam int          INIT_COUNT = 5;
   localparam logic [16:0] INIT_CODES [INIT_COUNT] = '{
      17'd12345, 17'd55555, 17'd77777, 17'd98765, 17'd11111
   };

   localparam logic [2:0]  MISS_MAX      = 3'd7;
   localparam logic [2:0]  LIMIT_RESET   = 3'd3;
   localparam logic [3:0]  DIGIT_MIN     = 4'd1;
   localparam logic [3:0]  DIGIT_MAX     = 4'd9;

   // x / 10 == (x * 0xCCCCCCCD) >> 35 for every 32-bit x
   localparam logic [31:0] DIV10_MUL   = 32'hCCCCCCCD;
   localparam int          DIV10_SHIFT = 35;

endpackage

// File: rtl/core/kcl_core.sv
module kcl_core #(
   parameter int CODE_DIGITS = 5,
   parameter int NUM_CODES   = 5
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  kcl_pkg::item_type   item,
   input  logic [2:0]          attempt_limit,
   output kcl_pkg::result_type result
);
   import kcl_pkg::*;

   localparam int ENTRY_W = $clog2(10 ** CODE_DIGITS);
   localparam int TABLE_W = (ENTRY_W > INIT_W) ? ENTRY_W : INIT_W;
   localparam int DCNT_W  = $clog2(CODE_DIGITS + 1);
   localparam int SLOT_W  = (NUM_CODES > 1) ? $clog2(NUM_CODES) : 1;

   mode_type             mode_ff,  mode_in;
   logic [ENTRY_W-1:0]   value_ff, value_in;
   logic [DCNT_W-1:0]    digits_ff, digits_in;
   logic [2:0]           miss_ff,  miss_in;
   logic [TABLE_W-1:0]   table_ff [NUM_CODES];
   logic                 table_we;
   logic [SLOT_W-1:0]    slot_ff,  slot_in;
   logic                 door_ff,  door_in;
   logic                 light_ff, light_in;
   status_type           status;

   logic [NUM_CODES-1:0] hit_vec;
   logic [SLOT_W-1:0]    hit_slot;
   logic [63:0]          div_prod;
   logic [ENTRY_W-1:0]   value_div10;
   logic [ENTRY_W-1:0]   value_push;
   logic [2:0]           miss_inc;
   logic                 full;

   // parallel comparators, lowest slot wins
   always_comb begin
      hit_slot = '0;
      for (int i = 0; i < NUM_CODES; i++) begin
         hit_vec[i] = (value_ff != '0) && (TABLE_W'(value_ff) == table_ff[i]);
      end
      for (int i = NUM_CODES - 1; i >= 0; i--) begin
         if (hit_vec[i]) begin
            hit_slot = SLOT_W'(i);
         end
      end
   end

   assign div_prod    = 64'(value_ff) * 64'(DIV10_MUL);
   assign value_div10 = ENTRY_W'(div_prod >> DIV10_SHIFT);
   assign value_push  = ENTRY_W'({value_ff, 3'b000}) + ENTRY_W'({value_ff, 1'b0})
                        + ENTRY_W'(item.digit);
   assign miss_inc    = (miss_ff < MISS_MAX) ? (miss_ff + 3'd1) : miss_ff;
   assign full        = (digits_ff >= DCNT_W'(CODE_DIGITS));

   always_comb begin
      mode_in   = mode_ff;
      value_in  = value_ff;
      digits_in = digits_ff;
      miss_in   = miss_ff;
      slot_in   = slot_ff;
      door_in   = door_ff;
      light_in  = light_ff;
      table_we  = 1'b0;
      status    = ST_IGNORED;

      if ((mode_ff == MODE_LOCKED || mode_ff == MODE_CHANGE) && item.kind <= KEY_SUBMIT) begin
         case (item.kind)
            KEY_DIGIT: begin
               if (item.digit >= DIGIT_MIN && item.digit <= DIGIT_MAX) begin
                  if (full) begin
                     status = ST_MAX;
                  end else begin
                     value_in  = value_push;
                     digits_in = digits_ff + DCNT_W'(1);
                     status    = ST_OK;
                  end
               end
            end
            KEY_DELETE: begin
               if (digits_ff != '0) begin
                  value_in  = value_div10;
                  digits_in = digits_ff - DCNT_W'(1);
               end
               status = ST_OK;
            end
            KEY_CLEAR: begin
               value_in  = '0;
               digits_in = '0;
               status    = ST_OK;
            end
            default: begin
               if (mode_ff == MODE_LOCKED) begin
                  value_in  = '0;
                  digits_in = '0;
                  if (hit_vec != '0) begin
                     miss_in  = '0;
                     light_in = 1'b0;
                     slot_in  = hit_slot;
                     mode_in  = MODE_UNLOCKED;
                     status   = ST_GRANTED;
                  end else begin
                     miss_in  = miss_inc;
                     light_in = 1'b1;
                     if (miss_inc >= attempt_limit) begin
                        mode_in = MODE_ALARM;
                     end
                     status = ST_WRONG;
                  end
               end else if (!full) begin
                  status = ST_SHORT;
               end else begin
                  table_we  = 1'b1;
                  value_in  = '0;
                  digits_in = '0;
                  mode_in   = MODE_UNLOCKED;
                  status    = ST_CHANGED;
               end
            end
         endcase
      end else if (mode_ff == MODE_UNLOCKED) begin
         case (item.kind)
            KEY_CHANGE: begin
               value_in  = '0;
               digits_in = '0;
               mode_in   = MODE_CHANGE;
               status    = ST_OK;
            end
            KEY_DOOR: begin
               door_in = ~door_ff;
               status  = ST_OK;
            end
            KEY_LIGHT: begin
               light_in = ~light_ff;
               status   = ST_OK;
            end
            default: begin
               status = ST_IGNORED;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_LOCKED;
         value_ff  <= '0;
         digits_ff <= '0;
         miss_ff   <= '0;
         slot_ff   <= '0;
         door_ff   <= 1'b0;
         light_ff  <= 1'b1;
         for (int i = 0; i < NUM_CODES; i++) begin
            table_ff[i] <= TABLE_W'(INIT_CODES[i % INIT_COUNT]);
         end
      end else if (step) begin
         mode_ff   <= mode_in;
         value_ff  <= value_in;
         digits_ff <= digits_in;
         miss_ff   <= miss_in;
         slot_ff   <= slot_in;
         door_ff   <= door_in;
         light_ff  <= light_in;
         for (int i = 0; i < NUM_CODES; i++) begin
            if (table_we && slot_ff == SLOT_W'(i)) begin
               table_ff[i] <= TABLE_W'(value_ff);
            end
         end
      end
   end

   assign result.mode           = mode_in;
   assign result.status         = status;
   assign result.digits_entered = 3'(digits_in);
   assign result.wrong_attempts = miss_in;
   assign result.door_open      = door_in;
   assign result.light_on       = light_in;

endmodule

// File: rtl/core/keypad_code_lock.sv
// channel  | dir | handshake              | payload
// ---------+-----+------------------------+------------------------------------------
// req      | in  | req_tvalid/req_tready  | tuser: kind; tdata: digit, zero pad
// rsp      | out | rsp_tvalid/rsp_tready  | tdata: mode,status,digits,wrong,door,light
// csr      | in  | csr_valid/csr_ready    | csr_data: attempt_limit
//
// Each key word passes from acceptance through the input register, then through the step
// logic (code compare, x10 / div10) into the result register.
// A new word is accepted every cycle as long as the result register drains.
// Reset is synchronous, active high: locked, empty entry, light on, default codes.
// A stalled result holds the input register; req_tready drops only when both are full.
module keypad_code_lock #(
   parameter int CODE_DIGITS = 5,
   parameter int NUM_CODES   = 5
) (
   input  logic        clock,
   input  logic        reset,
   // key words
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [3:0] digit, [7:4] zero
   input  logic [2:0]  req_tuser,   // [2:0] kind
   // result words
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [1:0] mode, [4:2] status, [7:5] digits_entered,
                                    // [10:8] wrong_attempts, [11] door_open,
                                    // [12] light_on, [15:13] zero
   // attempt limit register
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_data
);
   import kcl_pkg::*;

   logic       in_valid_ff, in_valid_in;
   item_type   in_item_ff;
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_data_ff;
   result_type step_result;
   logic [2:0] limit_ff;
   logic       advance;

   // the step fires when the input register holds a word and the result slot frees up
   assign advance      = !rsp_valid_ff || rsp_tready;
   assign req_tready   = !in_valid_ff || advance;
   assign in_valid_in  = (req_tvalid && req_tready) || (in_valid_ff && !advance);
   assign rsp_valid_in = (in_valid_ff && advance) || (rsp_valid_ff && !rsp_tready);
   assign csr_ready    = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         limit_ff     <= LIMIT_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid) begin
            limit_ff <= csr_data;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_item_ff.kind  <= req_tuser;
         in_item_ff.digit <= req_tdata[3:0];
      end
      if (in_valid_ff && advance) begin
         rsp_data_ff <= step_result;
      end
   end

   kcl_core #(
      .CODE_DIGITS (CODE_DIGITS),
      .NUM_CODES   (NUM_CODES)
   ) u_core (
      .clock         (clock),
      .reset         (reset),
      .step          (in_valid_ff && advance),
      .item          (in_item_ff),
      .attempt_limit (limit_ff),
      .result        (step_result)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000,
                        rsp_data_ff.light_on,
                        rsp_data_ff.door_open,
                        rsp_data_ff.wrong_attempts,
                        rsp_data_ff.digits_entered,
                        rsp_data_ff.status,
                        rsp_data_ff.mode};

`include "keypad_code_lock_assert.svh"

   // alarm never clears on its own
   `KCL_CHECK_NEXT(a_alarm_holds, rsp_valid_ff && rsp_tready && rsp_data_ff.mode == MODE_ALARM, !rsp_valid_ff || rsp_data_ff.mode == MODE_ALARM, "alarm left without reset")
   // a grant leaves the lock open, entry empty, misses cleared, light off
   `KCL_CHECK_NOW(a_grant_state, rsp_valid_ff && rsp_data_ff.status == ST_GRANTED, rsp_data_ff.mode == MODE_UNLOCKED && rsp_data_ff.wrong_attempts == 3'd0 && rsp_data_ff.digits_entered == 3'd0 && !rsp_data_ff.light_on, "bad state after grant")
   // a miss empties the entry and turns the light on
   `KCL_CHECK_NOW(a_wrong_state, rsp_valid_ff && rsp_data_ff.status == ST_WRONG, rsp_data_ff.digits_entered == 3'd0 && rsp_data_ff.light_on && rsp_data_ff.wrong_attempts != 3'd0, "bad state after miss")
   // a waiting key word is neither lost nor altered while the result stalls
   `KCL_CHECK_NEXT(a_in_hold, in_valid_ff && !advance, in_valid_ff && $stable(in_item_ff), "input word dropped during stall")

endmodule
